[hw/rtl/ptbg_pkg.sv]
package ptbg_pkg;

  localparam int TS_W    = 64;
  localparam int RATE_W  = 32;
  localparam int BKT_W   = 20;
  localparam int TOK_W   = 21;
  localparam int CNT_W   = 16;
  localparam int PORT_W  = 3;
  localparam int MOVE_W  = 11;
  localparam int CFG_W   = 32;
  localparam int CFG_A_W = 2;

  typedef logic [TS_W-1:0]    stamp_t;
  typedef logic [TOK_W-1:0]   token_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [PORT_W-1:0]  port_id_t;
  typedef logic [MOVE_W-1:0]  move_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;
  typedef logic [CFG_A_W-1:0] cfg_index_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_POLL  = 1'b1
  } op_t;

  localparam cfg_index_t REG_SHAPING_ENABLE  = 2'd0;
  localparam cfg_index_t REG_RATE_PER_CYCLE  = 2'd1;
  localparam cfg_index_t REG_BUCKET_BYTES    = 2'd2;
  localparam cfg_index_t REG_QUEUE_THRESHOLD = 2'd3;

  localparam logic [BKT_W-1:0] BUCKET_RESET    = 20'd65536;
  localparam count_t           THRESHOLD_RESET = 16'd64;

endpackage

[hw/rtl/port_token_bucket_tx_gate.sv]
// per-port token bucket transmit shaper
// input channel (in_valid / in_stall): one event per beat, a start that
// loads the port's time and fills its bucket, or a poll that, with shaping
// enabled, refills the bucket from elapsed cycles and gates the port when it
// holds less than one bucket, and otherwise reports the top-up move count and
// whether the head packet goes out, taking its length from the tokens.
// output channel (out_valid / out_stall): exactly one result beat per event.
// config port: cfg_write with cfg_index / cfg_data, written only while idle:
// a rule for the user that the block does not enforce. a new event is taken
// only after the one before leaves its last step. the per-port state sits in
// two memories with a registered read, and the 32x64 refill product goes
// through one shared 32x32 multiplier in two passes, followed by a sum and
// a saturate step before the write-back. a result waiting under out_stall
// does not block the next input beat; the event after it holds in its last
// step until the output register frees. reset clears the config registers
// to their defaults, empties the pipeline and marks every port entry
// unwritten, so it reads as zero time and zero tokens until its first write.
module port_token_bucket_tx_gate #(
  parameter int PORTS     = 8,
  parameter int FRAC_BITS = 16,
  parameter int MAX_BURST = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  ptbg_pkg::cfg_index_t cfg_index,
  input  ptbg_pkg::cfg_data_t  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  ptbg_pkg::port_id_t   port,
  input  ptbg_pkg::stamp_t     timestamp,
  input  ptbg_pkg::count_t     tx_queue_count,
  input  ptbg_pkg::count_t     long_queue_count,
  input  ptbg_pkg::count_t     head_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 gated,
  output ptbg_pkg::move_t      move_count,
  output logic                 send,
  output ptbg_pkg::token_t     token_level
);
  import ptbg_pkg::*;

  localparam int IDX_W  = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int PROD_W = TS_W + RATE_W;
  localparam count_t BURST_MAX = CNT_W'(MAX_BURST);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MUL_LO, ST_MUL_HI, ST_SUM, ST_REF, ST_FIN
  } state_t;

  state_t state;

  // config registers
  logic              shaping_enable;
  logic [RATE_W-1:0] rate_per_cycle;
  logic [BKT_W-1:0]  bucket_bytes;
  count_t            queue_threshold;

  // latched event
  op_t              op_q;
  logic [IDX_W-1:0] idx_q;
  logic             in_range_q;
  stamp_t           ts_q;
  count_t           txc_q;
  count_t           lqc_q;
  count_t           hlen_q;

  // port memories
  stamp_t           mem_last [PORTS];
  token_t           mem_tok [PORTS];
  logic [PORTS-1:0] written;
  stamp_t           rd_last;
  token_t           rd_tok;
  logic             rd_vld;

  // datapath registers
  stamp_t              elapsed;
  logic [2*RATE_W-1:0] prod_lo;
  logic [2*RATE_W-1:0] prod_hi;
  logic [PROD_W-1:0]   product;
  token_t              tok_ref;
  count_t              move_q;

  logic             in_accept;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;
  logic             out_blocked;
  logic             mem_we;
  logic             fin_we;

  logic [RATE_W-1:0]   mul_b;
  logic [2*RATE_W-1:0] mul_p;

  count_t gap;
  count_t move_next;

  token_t            t_cur;
  token_t            cap;
  logic              at_cap;
  token_t            room;
  logic [PROD_W-1:0] shifted;
  logic              big;
  token_t            add;
  token_t            tok_ref_next;

  logic   gated_next;
  logic   send_next;
  token_t level_next;
  count_t move_fin;

  assign in_accept   = in_valid && !in_stall;
  assign in_stall    = rst || (state != ST_IDLE);
  assign in_idx      = IDX_W'(port);
  assign in_range    = ({1'b0, port} < (PORT_W + 1)'(PORTS)) || (PORTS > (1 << PORT_W));
  assign out_blocked = out_valid && out_stall;
  assign mem_we      = (state == ST_FIN) && !out_blocked && fin_we;

  // one multiplier, two passes over the elapsed count
  assign mul_b = (state == ST_MUL_LO) ? elapsed[RATE_W-1:0] : elapsed[TS_W-1:RATE_W];
  assign mul_p = {{RATE_W{1'b0}}, rate_per_cycle} * {{RATE_W{1'b0}}, mul_b};

  // top-up from the overflow queue
  always_comb begin
    gap       = queue_threshold - txc_q;
    move_next = '0;
    if ((txc_q < queue_threshold) && (lqc_q != '0)) begin
      move_next = (gap >= lqc_q) ? lqc_q : gap;
      if (move_next > BURST_MAX) begin
        move_next = BURST_MAX;
      end
    end
  end

  // refill with saturation at twice the bucket
  always_comb begin
    t_cur   = rd_vld ? rd_tok : '0;
    cap     = {bucket_bytes, 1'b0};
    at_cap  = (t_cur >= cap);
    room    = at_cap ? '0 : cap - t_cur;
    shifted = product >> FRAC_BITS;
    big     = |shifted[PROD_W-1:TOK_W];
    add     = (big || (shifted[TOK_W-1:0] >= room)) ? room : shifted[TOK_W-1:0];
    if (!shaping_enable) begin
      tok_ref_next = t_cur;
    end else if (at_cap) begin
      tok_ref_next = cap;
    end else begin
      tok_ref_next = t_cur + add;
    end
  end

  // final decision and write-back value
  always_comb begin
    gated_next = 1'b0;
    send_next  = 1'b0;
    move_fin   = '0;
    level_next = '0;
    fin_we     = 1'b0;
    if (in_range_q) begin
      unique case (op_q)
        OP_START: begin
          level_next = {1'b0, bucket_bytes};
          fin_we     = 1'b1;
        end
        OP_POLL: begin
          fin_we     = shaping_enable;
          level_next = tok_ref;
          if (shaping_enable && (tok_ref < {1'b0, bucket_bytes})) begin
            gated_next = 1'b1;
          end else begin
            move_fin  = move_q;
            send_next = (txc_q != '0) || (move_q != '0);
            if (send_next && shaping_enable) begin
              level_next = (tok_ref > {{(TOK_W-CNT_W){1'b0}}, hlen_q}) ?
                           tok_ref - {{(TOK_W-CNT_W){1'b0}}, hlen_q} : '0;
            end
          end
        end
        default: begin
          level_next = '0;
        end
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_last[idx_q] <= ts_q;
      mem_tok[idx_q]  <= level_next;
    end
    if (in_accept) begin
      rd_last <= mem_last[in_idx];
      rd_tok  <= mem_tok[in_idx];
    end
  end

  // control, config and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      shaping_enable  <= 1'b0;
      rate_per_cycle  <= '0;
      bucket_bytes    <= BUCKET_RESET;
      queue_threshold <= THRESHOLD_RESET;
      written         <= '0;
      rd_vld          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SHAPING_ENABLE:  shaping_enable  <= cfg_data[0];
          REG_RATE_PER_CYCLE:  rate_per_cycle  <= cfg_data[RATE_W-1:0];
          REG_BUCKET_BYTES:    bucket_bytes    <= cfg_data[BKT_W-1:0];
          REG_QUEUE_THRESHOLD: queue_threshold <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if ((state == ST_FIN) && !out_blocked) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        written[idx_q] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            rd_vld <= in_range && written[in_idx];
            state  <= ST_RD;
          end
        end
        ST_RD:     state <= ST_MUL_LO;
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: state <= ST_SUM;
        ST_SUM:    state <= ST_REF;
        ST_REF:    state <= ST_FIN;
        ST_FIN: begin
          if (!out_blocked) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q       <= op_t'(operation);
      idx_q      <= in_idx;
      in_range_q <= in_range;
      ts_q       <= timestamp;
      txc_q      <= tx_queue_count;
      lqc_q      <= long_queue_count;
      hlen_q     <= head_length;
    end
    unique case (state)
      ST_RD: begin
        elapsed <= ts_q - (rd_vld ? rd_last : '0);
        move_q  <= move_next;
      end
      ST_MUL_LO: prod_lo <= mul_p;
      ST_MUL_HI: prod_hi <= mul_p;
      ST_SUM:    product <= {{RATE_W{1'b0}}, prod_lo} + {prod_hi, {RATE_W{1'b0}}};
      ST_REF:    tok_ref <= tok_ref_next;
      ST_FIN: begin
        if (!out_blocked) begin
          gated       <= gated_next;
          move_count  <= move_fin[MOVE_W-1:0];
          send        <= send_next;
          token_level <= level_next;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_RD)
    else $error("accepted beat did not start a memory read");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !in_accept)
    else $error("write-back overlaps a new read");

  a_fin_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) && !out_blocked |=> out_valid && state == ST_IDLE)
    else $error("finished event not presented");

  a_gated_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && gated |-> !send && move_count == '0)
    else $error("gated result moves or sends");

endmodule
